### design/wsg_pkg.sv
// wsg_pkg: shared constants of the waypoint smoother with send gate
// holds the cordic arctangent table, register addresses and reset values
// no dependencies
package wsg_pkg;

  // longest cordic run that the arctangent table supports
  localparam int unsigned AtanLen = 24;

  // register index in paddr[3:2]
  localparam logic [1:0] RegAlpha   = 2'd0;
  localparam logic [1:0] RegMinDist = 2'd1;
  localparam logic [1:0] RegMinYaw  = 2'd2;

  // register reset values
  localparam logic [16:0] AlphaReset   = 17'd26214;
  localparam logic [30:0] MinDistReset = 31'd6554;
  localparam logic [15:0] MinYawReset  = 16'd261;

  // unity weight in Q1.16
  localparam logic [16:0] AlphaOne = 17'd65536;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### design/waypoint_smoother_with_send_gate.sv
// waypoint_smoother_with_send_gate: ema of x, y and heading with a send gate
// one shared multiplier and one shared cordic step unit under a sequencer
// depends on wsg_pkg
// a seeding sample goes straight to the send gate; a blended sample first runs the
// position blend, two cordic rotations and, unless the weighted sums are zero, one
// vectoring run; a restart only clears history. One item at a time, in_ready high only
// while idle; the cordic step unit runs up to three times per blended sample
// reset: rst_ni async low, clears the filter and send history, loads register defaults
module waypoint_smoother_with_send_gate #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic signed [31:0] raw_x_i,
  input  logic signed [31:0] raw_y_i,
  input  logic signed [15:0] raw_yaw_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [15:0] out_yaw_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Steps = (CORDIC_STEPS > int'(wsg_pkg::AtanLen)) ?
                         int'(wsg_pkg::AtanLen) : CORDIC_STEPS;
  localparam int CntW  = $clog2(Steps);

  typedef enum logic [4:0] {
    S_IDLE, S_PX, S_PY, S_RINIT, S_ROT, S_MC, S_MS, S_MT,
    S_VINIT, S_VEC, S_G1, S_G2, S_G3, S_G4, S_PUSH
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic              sel_q, neg_q;
  logic              smooth_valid_q, sent_valid_q, out_valid_q;
  logic [16:0]       alpha_q;
  logic [30:0]       min_dist_q;
  logic [15:0]       min_yaw_q;

  logic signed [31:0] raw_x_q, raw_y_q, sx_q, sy_q, tx_q, ty_q, ox_q, oy_q;
  logic signed [15:0] raw_yaw_q, sh_q, th_q, oh_q;
  logic signed [51:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic signed [49:0] accc_q, accs_q;
  logic signed [67:0] prod_q;
  logic [65:0]        sum_q;

  // clamped weights
  logic [16:0] wa, wsel;
  assign wa   = (alpha_q > wsg_pkg::AlphaOne) ? wsg_pkg::AlphaOne : alpha_q;
  assign wsel = sel_q ? (wsg_pkg::AlphaOne - wa) : wa;

  // differences for blend and gate
  logic signed [32:0] bdx, bdy, gdx, gdy;
  assign bdx = {raw_x_q[31], raw_x_q} - {sx_q[31], sx_q};
  assign bdy = {raw_y_q[31], raw_y_q} - {sy_q[31], sy_q};
  assign gdx = {sx_q[31], sx_q} - {tx_q[31], tx_q};
  assign gdy = {sy_q[31], sy_q} - {ty_q[31], ty_q};

  // shared multiplier operand select
  logic signed [33:0] ma, mb, cx, cy;
  assign cx = neg_q ? -x_q[33:0] : x_q[33:0];
  assign cy = neg_q ? -y_q[33:0] : y_q[33:0];
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_PX: begin ma = {17'd0, wa}; mb = {bdx[32], bdx}; end
      S_PY: begin ma = {17'd0, wa}; mb = {bdy[32], bdy}; end
      S_MC: begin ma = {17'd0, wsel}; mb = cx; end
      S_MS: begin ma = {17'd0, wsel}; mb = cy; end
      S_G1: begin ma = {gdx[32], gdx}; mb = {gdx[32], gdx}; end
      S_G2: begin ma = {gdy[32], gdy}; mb = {gdy[32], gdy}; end
      S_G3: begin ma = {3'd0, min_dist_q}; mb = {3'd0, min_dist_q}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // position blend step, rounded and floor shifted
  logic [67:0] pos_r;
  assign pos_r = prod_q + 68'sd32768;

  // shared cordic step unit, rotation and vectoring
  logic               dir;
  logic signed [51:0] xs, ys, x_n, y_n;
  logic signed [33:0] at, z_n, zr;
  assign dir = (state_q == S_ROT) ? !z_q[33] : !(!y_q[51] && (y_q != '0));
  assign xs  = x_q >>> cnt_q;
  assign ys  = y_q >>> cnt_q;
  assign at  = {2'b00, wsg_pkg::atan_turn(5'(cnt_q))};
  assign x_n = dir ? (x_q - ys) : (x_q + ys);
  assign y_n = dir ? (y_q + xs) : (y_q - xs);
  assign z_n = dir ? (z_q - at) : (z_q + at);
  assign zr  = z_n + 34'sd32768;

  // rotation start angle, folded into half circle
  logic signed [15:0] ryaw;
  logic signed [33:0] z0;
  logic               fold_hi, fold_lo;
  assign ryaw    = sel_q ? sh_q : raw_yaw_q;
  assign z0      = {{2{ryaw[15]}}, ryaw, 16'd0};
  assign fold_hi = z0 > 34'sd1073741824;
  assign fold_lo = z0 < -34'sd1073741824;

  // gate compares
  logic [15:0] dh;
  logic [16:0] adh;
  logic        dist_hit, yaw_hit;
  assign dh       = sh_q - th_q;
  assign adh      = dh[15] ? (17'd0 - {1'b1, dh}) : {1'b0, dh};
  assign dist_hit = sum_q >= {4'd0, prod_q[61:0]};
  assign yaw_hit  = adh >= {1'b0, min_yaw_q};

  logic in_acc, restart, push;
  assign in_acc  = in_valid_i && in_ready_o;
  assign restart = in_acc && action_i;
  assign push    = (state_q == S_PUSH) && (!out_valid_q || out_ready_i);

  logic last;
  assign last = cnt_q == CntW'(Steps - 1);

  // sequencer, flags and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      cnt_q          <= '0;
      sel_q          <= 1'b0;
      neg_q          <= 1'b0;
      smooth_valid_q <= 1'b0;
      sent_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
      alpha_q        <= wsg_pkg::AlphaReset;
      min_dist_q     <= wsg_pkg::MinDistReset;
      min_yaw_q      <= wsg_pkg::MinYawReset;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          wsg_pkg::RegAlpha:   alpha_q    <= pwdata[16:0];
          wsg_pkg::RegMinDist: min_dist_q <= pwdata[30:0];
          wsg_pkg::RegMinYaw:  min_yaw_q  <= pwdata[15:0];
          default: ;
        endcase
      end
      // output register loads on push, frees on accept
      if (push) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (restart) begin
            smooth_valid_q <= 1'b0;
            sent_valid_q   <= 1'b0;
          end else if (in_acc) begin
            smooth_valid_q <= 1'b1;
            sel_q          <= 1'b0;
            state_q        <= smooth_valid_q ? S_PX : S_G1;
          end
        end
        S_PX:    state_q <= S_PY;
        S_PY:    state_q <= S_RINIT;
        S_RINIT: begin
          neg_q   <= fold_hi || fold_lo;
          cnt_q   <= '0;
          state_q <= S_ROT;
        end
        S_ROT: begin
          cnt_q <= cnt_q + 1'b1;
          if (last) state_q <= S_MC;
        end
        S_MC:    state_q <= S_MS;
        S_MS:    state_q <= S_MT;
        S_MT: begin
          sel_q   <= 1'b1;
          state_q <= sel_q ? S_VINIT : S_RINIT;
        end
        S_VINIT: begin
          cnt_q   <= '0;
          state_q <= (accc_q == '0 && accs_q == '0) ? S_G1 : S_VEC;
        end
        S_VEC: begin
          cnt_q <= cnt_q + 1'b1;
          if (last) state_q <= S_G1;
        end
        S_G1:    state_q <= sent_valid_q ? S_G2 : S_PUSH;
        S_G2:    state_q <= S_G3;
        S_G3:    state_q <= S_G4;
        S_G4:    state_q <= (dist_hit || yaw_hit) ? S_PUSH : S_IDLE;
        S_PUSH: begin
          if (push) begin
            sent_valid_q <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    if (in_acc && !action_i) begin
      raw_x_q   <= raw_x_i;
      raw_y_q   <= raw_y_i;
      raw_yaw_q <= raw_yaw_i;
      if (!smooth_valid_q) begin
        sx_q <= raw_x_i;
        sy_q <= raw_y_i;
        sh_q <= raw_yaw_i;
      end
    end
    case (state_q)
      S_PX: begin
        accc_q <= '0;
        accs_q <= '0;
      end
      S_PY: sx_q <= sx_q + pos_r[47:16];
      S_RINIT: begin
        if (!sel_q) sy_q <= sy_q + pos_r[47:16];
        x_q <= 52'sd1073741824;
        y_q <= '0;
        if (fold_hi)      z_q <= z0 - 34'sd2147483648;
        else if (fold_lo) z_q <= z0 + 34'sd2147483648;
        else              z_q <= z0;
      end
      S_ROT, S_VEC: begin
        x_q <= x_n;
        y_q <= y_n;
        z_q <= z_n;
        if (state_q == S_VEC && last) sh_q <= zr[31:16];
      end
      S_MS: accc_q <= accc_q + prod_q[49:0];
      S_MT: accs_q <= accs_q + prod_q[49:0];
      S_VINIT: begin
        if (accc_q == '0 && accs_q == '0) begin
          sh_q <= '0;
        end else if (accc_q[49]) begin
          x_q <= -{{2{accc_q[49]}}, accc_q};
          y_q <= -{{2{accs_q[49]}}, accs_q};
          z_q <= 34'sd2147483648;
        end else begin
          x_q <= {{2{accc_q[49]}}, accc_q};
          y_q <= {{2{accs_q[49]}}, accs_q};
          z_q <= '0;
        end
      end
      S_G2: sum_q <= prod_q[65:0];
      S_G3: sum_q <= sum_q + prod_q[65:0];
      S_PUSH: begin
        if (push) begin
          tx_q <= sx_q;
          ty_q <= sy_q;
          th_q <= sh_q;
          ox_q <= sx_q;
          oy_q <= sy_q;
          oh_q <= sh_q;
        end
      end
      default: ;
    endcase
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      wsg_pkg::RegAlpha:   prdata = {15'd0, alpha_q};
      wsg_pkg::RegMinDist: prdata = {1'b0, min_dist_q};
      wsg_pkg::RegMinYaw:  prdata = {16'd0, min_yaw_q};
      default:             prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_yaw_o   = oh_q;

`ifndef ASSERT_OFF
  // cordic step counter stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROT || state_q == S_VEC) |-> (cnt_q <= CntW'(Steps - 1)))
    else $error("cordic step counter out of range");

  // restart beat clears filter and send history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (!smooth_valid_q && !sent_valid_q))
    else $error("restart did not clear history");

  // a pushed result leaves a valid output beat and send history
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> (out_valid_q && sent_valid_q && state_q == S_IDLE))
    else $error("result push incomplete");

  // a result is only pushed once the filter holds a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> smooth_valid_q)
    else $error("push without filter state");
`endif

endmodule
